// File: rtl/core/xtea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// XTEA cipher package
// Shared constants, types and the per-cell round sum constants.
// ---------------------------------------------------------------------------
package xtea_pkg;

   localparam int ROUNDS    = 32;
   localparam int STAGES    = 2 * ROUNDS;
   localparam int KEY_WORDS = 4;
   localparam int ADDR_W    = 4;

   localparam logic [31:0] DELTA = 32'h9E3779B9;

   // Operation codes carried in the mode field.
   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef logic [KEY_WORDS-1:0][31:0] key_type;

   typedef struct packed {
      logic        mode;
      logic [31:0] left;
      logic [31:0] right;
   } item_type;

   // Sum seen by half-round k when encrypting.
   function automatic logic [31:0] enc_sum(input int k);
      logic [31:0] n;
      n = 32'((k >> 1) + (k & 1));
      return DELTA * n;
   endfunction

   // Sum seen by half-round k when decrypting.
   function automatic logic [31:0] dec_sum(input int k);
      logic [31:0] n;
      n = 32'(ROUNDS - (k >> 1) - (k & 1));
      return DELTA * n;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/xtea_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// XTEA key registers
// APB-style access to the four 32-bit key words.
// ---------------------------------------------------------------------------
module xtea_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [xtea_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic      [31:0]                 csr_prdata,
   output logic                             csr_pready,
   output xtea_pkg::key_type                key
);
   import xtea_pkg::*;

   key_type    key_ff;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[ADDR_W-1:2];
   assign csr_prdata = key_ff[reg_index];
   assign key        = key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         key_ff[reg_index] <= csr_pwdata;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/xtea_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// XTEA half-round cell
// One half of a Feistel round, registered, for either direction.
// ---------------------------------------------------------------------------
module xtea_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  xtea_pkg::key_type       key,
   input  wire logic [31:0]        enc_sum,
   input  wire logic [31:0]        dec_sum,
   input  wire logic               odd,
   input  wire logic               in_valid,
   input  xtea_pkg::item_type      in_item,
   output logic                    out_valid,
   output xtea_pkg::item_type      out_item
);
   import xtea_pkg::*;

   logic        decrypt;
   logic        upd_left;
   logic [31:0] src;
   logic [31:0] dst;
   logic [31:0] sum;
   logic [1:0]  kidx;
   logic [31:0] mix;
   logic [31:0] term;
   logic [31:0] res;
   item_type    item_in;
   item_type    item_ff;
   logic        valid_in;
   logic        valid_ff;

   // Encryption updates the left word in even cells; decryption runs the
   // halves in reverse, so it updates the left word in odd cells.
   always_comb begin
      decrypt  = (in_item.mode == MODE_DECRYPT);
      upd_left = (decrypt == odd);
      src      = upd_left ? in_item.right : in_item.left;
      dst      = upd_left ? in_item.left  : in_item.right;
      sum      = decrypt ? dec_sum : enc_sum;
      kidx     = upd_left ? sum[1:0] : sum[12:11];
      mix      = ((src << 4) ^ (src >> 5)) + src;
      term     = mix ^ (sum + key[kidx]);
      res      = decrypt ? (dst - term) : (dst + term);
      item_in  = in_item;
      if (upd_left) begin
         item_in.left = res;
      end else begin
         item_in.right = res;
      end
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

// File: rtl/core/xtea_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// XTEA output stage
// Output register plus skid register between the cell chain and the result.
// ---------------------------------------------------------------------------
module xtea_out_stage (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  xtea_pkg::item_type in_item,
   output logic               advance,
   output logic               out_valid,
   output logic [31:0]        out_left,
   output logic [31:0]        out_right,
   input  wire logic          out_ready
);
   import xtea_pkg::*;

   logic        out_valid_ff;
   logic        out_valid_in;
   logic        skid_valid_ff;
   logic        skid_valid_in;
   logic [63:0] out_data_ff;
   logic [63:0] out_data_in;
   logic [63:0] skid_data_ff;
   logic [63:0] skid_data_in;
   logic        take;
   logic        moving;

   assign advance = !skid_valid_ff;
   assign take    = out_valid_ff && out_ready;
   assign moving  = advance && in_valid;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (moving) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = {in_item.right, in_item.left};
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = {in_item.right, in_item.left};
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_left  = out_data_ff[31:0];
   assign out_right = out_data_ff[63:32];

endmodule
`default_nettype wire

// File: rtl/core/xtea_block_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// XTEA block cipher
// Fully pipelined 64-bit XTEA encrypt/decrypt under a 128-bit key.
// ---------------------------------------------------------------------------
// Usage:
// Items arrive on the req_ stream: req_tdata carries the 64-bit block and
// req_tuser selects encryption (0) or decryption (1). Each item leaves on the
// rsp_ stream as the transformed 64-bit block. Blocks are independent.
// The key is four 32-bit words at byte addresses 0, 4, 8 and 12 of the csr_
// APB port; they reset to zero and should only be changed while no item is
// in flight.
// The datapath is a row of 2*ROUNDS half-round cells, each a registered
// stage, followed by an output register. The first cell captures the item at
// the accepting edge; the item then passes through every cell register and
// the output register before rsp_tvalid rises. One item is accepted every
// cycle while the chain is not held, set by the one-cell-per-half-round chain.
// When the receiver stalls, the output register holds its item and a skid
// register catches the next one; only once the skid register is full does
// req_tready drop, and the whole chain holds in place until the output is
// taken. Reset clears every valid bit and the key, so no item survives it.
// ---------------------------------------------------------------------------
module xtea_block_cipher (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // Input stream.
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [63:0]                 req_tdata,  // left_word[31:0], right_word[63:32]
   input  wire logic                        req_tuser,  // mode[0]
   // Result stream.
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic      [63:0]                 rsp_tdata,  // out_left[31:0], out_right[63:32]
   // Key register port.
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [xtea_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic      [31:0]                 csr_prdata,
   output logic                             csr_pready
);
   import xtea_pkg::*;

   key_type     key;
   logic        advance;
   logic        chain_valid [STAGES+1];
   item_type    chain_item  [STAGES+1];
   logic [31:0] out_left;
   logic [31:0] out_right;

   xtea_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key         (key)
   );

   // The first cell takes the incoming item whenever the chain advances.
   assign req_tready        = advance;
   assign chain_valid[0]    = req_tvalid;
   assign chain_item[0]     = '{mode: req_tuser, left: req_tdata[31:0],
                                right: req_tdata[63:32]};

   // Each cell gets its own round sums as constants; the direction of the
   // item picks which one it uses.
   for (genvar k = 0; k < STAGES; k++) begin : g_cell
      xtea_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .key       (key),
         .enc_sum   (enc_sum(k)),
         .dec_sum   (dec_sum(k)),
         .odd       (1'(k & 1)),
         .in_valid  (chain_valid[k]),
         .in_item   (chain_item[k]),
         .out_valid (chain_valid[k+1]),
         .out_item  (chain_item[k+1])
      );
   end

   xtea_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[STAGES]),
      .in_item   (chain_item[STAGES]),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .out_left  (out_left),
      .out_right (out_right),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {out_right, out_left};

endmodule
`default_nettype wire

// File: rtl/core/xtea_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// XTEA port checker
// Port-level properties of the cipher, bound to the top level.
// ---------------------------------------------------------------------------
module xtea_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pwrite,
   input wire logic [3:0]  csr_paddr,
   input wire logic [31:0] csr_pwdata,
   input wire logic [31:0] csr_prdata,
   input wire logic        csr_pready
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // No result is shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Input is only refused while a result is waiting at the output.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input refused with no result pending");

   // A key write reads back at the next cycle.
   a_key_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready
      ##1 csr_psel && csr_penable && !csr_pwrite
          && csr_paddr[3:2] == $past(csr_paddr[3:2])
      |-> csr_prdata == $past(csr_pwdata))
      else $error("key register readback mismatch");

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (.*);
`default_nettype wire

// File: test/tb_xtea_block_cipher.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// XTEA block cipher testbench
// Streams 64-bit blocks through the cipher under several keys and checks
// each returned block against a cycle-free software XTEA predictor. The key
// registers are programmed and read back over the APB port while the
// pipeline is empty. Both stream sides idle at random, and one phase holds
// the result side off long enough for the pipeline to fill and stall.
// ---------------------------------------------------------------------------
module tb_xtea_block_cipher;
   import xtea_pkg::*;

   // Key register indexes; register i sits at byte address 4*i.
   typedef enum int {
      KEY_WORD_0 = 0,
      KEY_WORD_1 = 1,
      KEY_WORD_2 = 2,
      KEY_WORD_3 = 3
   } key_reg_index_type;

   // The pipeline is 2*ROUNDS half-round cells plus an output register; the
   // drain wait is sized from that depth so any straggler can show up.
   localparam int DRAIN_CYCLES = 2 * ROUNDS + 16;
   // Long receiver hold-off; well past the pipeline depth plus skid slot.
   localparam int HOLD_CYCLES  = 400;
   // Overall run limit in ns.
   localparam int RUN_LIMIT_NS = 2_000_000;

   typedef struct {
      bit [31:0] out_left;
      bit [31:0] out_right;
   } cipher_block_type;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Every input of the block starts at a known value.
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [63:0]         req_tdata   = '0;  // left_word[31:0], right_word[63:32]
   logic                req_tuser   = 1'b0; // mode[0]
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [63:0]         rsp_tdata;         // out_left[31:0], out_right[63:32]
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr   = '0;
   logic [31:0]         csr_pwdata  = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   // Shadow copy of the key as the block should hold it.
   bit [31:0]        key_shadow [KEY_WORDS];
   // Predicted output blocks, oldest first.
   cipher_block_type expected_blocks [$];
   int               error_count   = 0;
   // Percent of cycles in which each stream side idles.
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   // Forces the receiver to hold off while high.
   logic             rsp_hold      = 1'b0;

   xtea_block_cipher DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 4 ns period, first rising edge at 2 ns.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // -----------------------------------------------------------------------
   // Predictor
   // -----------------------------------------------------------------------

   // The XTEA Feistel mixing term of one half-round.
   function automatic bit [31:0] xtea_mix(input bit [31:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

   // Full XTEA transform of one block under the shadow key. Encryption walks
   // the round sum up from zero; decryption starts at DELTA*ROUNDS (mod 2^32)
   // and undoes the half-rounds in reverse order.
   function automatic cipher_block_type xtea_predict(input item_type blk);
      bit [31:0]        v0;
      bit [31:0]        v1;
      bit [31:0]        round_sum;
      cipher_block_type res;
      v0 = blk.left;
      v1 = blk.right;
      if (blk.mode == MODE_DECRYPT) begin
         round_sum = DELTA * 32'(ROUNDS);
         for (int r = 0; r < ROUNDS; r++) begin
            v1 -= xtea_mix(v0) ^ (round_sum + key_shadow[round_sum[12:11]]);
            round_sum -= DELTA;
            v0 -= xtea_mix(v1) ^ (round_sum + key_shadow[round_sum[1:0]]);
         end
      end else begin
         round_sum = '0;
         for (int r = 0; r < ROUNDS; r++) begin
            v0 += xtea_mix(v1) ^ (round_sum + key_shadow[round_sum[1:0]]);
            round_sum += DELTA;
            v1 += xtea_mix(v0) ^ (round_sum + key_shadow[round_sum[12:11]]);
         end
      end
      res.out_left  = v0;
      res.out_right = v1;
      return res;
   endfunction

   // Mostly uniform words, with the bit-pattern extremes mixed in often.
   function automatic bit [31:0] random_word();
      case ($urandom_range(15))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // -----------------------------------------------------------------------
   // Stream and register drivers. Each task starts and ends right after a
   // rising edge, and drives with nonblocking assignments.
   // -----------------------------------------------------------------------

   // Offers one item, after a random number of idle cycles, and records its
   // predicted output once the block takes it. req_tvalid is left high so
   // back-to-back items keep the stream busy without a bubble.
   task automatic send_block(input item_type blk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {blk.right, blk.left};
      req_tuser  <= blk.mode;
      do @(posedge clock); while (!req_tready);
      expected_blocks.push_back(xtea_predict(blk));
   endtask

   task automatic send_words(input logic mode, input bit [31:0] left, input bit [31:0] right);
      item_type blk;
      blk.mode  = mode;
      blk.left  = left;
      blk.right = right;
      send_block(blk);
   endtask

   // Stops offering items and waits until every predicted block has come
   // back. Every item yields a result, so nothing is left in flight then.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, then access until pready. A write updates
   // the shadow key; a read is checked against it.
   task automatic csr_access(input key_reg_index_type idx, input bit is_write,
                             input bit [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= ADDR_W'(4 * idx);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (is_write) begin
         key_shadow[idx] = data;
      end else if (csr_prdata !== key_shadow[idx]) begin
         $error("key register %0d readback: expected %h, actual %h",
                idx, key_shadow[idx], csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Writes all four key words, then reads each one back.
   task automatic program_key(input bit [31:0] k0, input bit [31:0] k1,
                              input bit [31:0] k2, input bit [31:0] k3);
      bit [31:0] words [KEY_WORDS];
      words = '{k0, k1, k2, k3};
      for (int i = 0; i < KEY_WORDS; i++)
         csr_access(key_reg_index_type'(i), 1'b1, words[i]);
      for (int i = 0; i < KEY_WORDS; i++)
         csr_access(key_reg_index_type'(i), 1'b0, '0);
   endtask

   // -----------------------------------------------------------------------
   // Result checker. Outputs are sampled at the rising edge, before any of
   // this edge's updates land, so the handshake seen here is the one that
   // completes at this edge. Each output block is matched against the oldest
   // prediction.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin : result_checker
      cipher_block_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (expected_blocks.size() == 0) begin
            $error("output block %h with no item outstanding", rsp_tdata);
            error_count++;
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_tdata[31:0] !== want.out_left) begin
               $error("out_left: expected %h, actual %h", want.out_left, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[63:32] !== want.out_right) begin
               $error("out_right: expected %h, actual %h", want.out_right, rsp_tdata[63:32]);
               error_count++;
            end
         end
      end
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // -----------------------------------------------------------------------
   // Tests
   // -----------------------------------------------------------------------

   // With the key still at its reset value of zero: the reset values read
   // back, and both operations run on every pairing of all-zero and all-one
   // words, and on single-bit blocks.
   task automatic test_zero_key_extremes();
      bit [31:0] corners [2];
      corners = '{32'h0000_0000, 32'hFFFF_FFFF};
      for (int i = 0; i < KEY_WORDS; i++)
         csr_access(key_reg_index_type'(i), 1'b0, '0);
      for (int m = 0; m < 2; m++) begin
         for (int l = 0; l < 2; l++)
            for (int r = 0; r < 2; r++)
               send_words(m ? MODE_DECRYPT : MODE_ENCRYPT, corners[l], corners[r]);
         send_words(m ? MODE_DECRYPT : MODE_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
         send_words(m ? MODE_DECRYPT : MODE_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
      end
      drain_pipeline();
   endtask

   // The all-ones key, then a key of alternating extremes, so words 0 and 2
   // of the key are seen at both values; words 1 and 3 stay all-ones.
   task automatic test_key_extremes();
      program_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_words(MODE_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_words(MODE_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
      drain_pipeline();
      program_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_words(MODE_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_words(MODE_DECRYPT, 32'h0000_0000, 32'h0000_0000);
      drain_pipeline();
   endtask

   // Encrypts a few blocks and then feeds the predicted ciphertexts back in
   // for decryption, which must give the plaintexts again.
   task automatic test_round_trip();
      item_type         plain [3];
      cipher_block_type cipher;
      program_key($urandom, $urandom, $urandom, $urandom);
      for (int i = 0; i < 3; i++) begin
         plain[i].mode  = MODE_ENCRYPT;
         plain[i].left  = $urandom;
         plain[i].right = $urandom;
         send_block(plain[i]);
      end
      for (int i = 0; i < 3; i++) begin
         cipher = xtea_predict(plain[i]);
         send_words(MODE_DECRYPT, cipher.out_left, cipher.out_right);
         if (expected_blocks[$].out_left != plain[i].left ||
             expected_blocks[$].out_right != plain[i].right) begin
            $error("round trip of block %0d does not restore the plaintext", i);
            error_count++;
         end
      end
      drain_pipeline();
   endtask

   // A fresh random key and a burst of random blocks in mixed modes, with
   // the given idle rates on each side.
   task automatic test_random_traffic(input int count, input int send_pct,
                                      input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      program_key(random_word(), random_word(), random_word(), random_word());
      for (int i = 0; i < count; i++)
         send_words($urandom_range(1) ? MODE_DECRYPT : MODE_ENCRYPT,
                    random_word(), random_word());
      drain_pipeline();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering items back to back. The pipeline and its skid slot fill up,
   // req_tready drops, and everything must come out intact once the hold
   // is released.
   task automatic test_backpressure(input int count);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_key($urandom, $urandom, $urandom, $urandom);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      for (int i = 0; i < count; i++)
         send_words($urandom_range(1) ? MODE_DECRYPT : MODE_ENCRYPT, $urandom, $urandom);
      drain_pipeline();
   endtask

   // -----------------------------------------------------------------------
   // Test sequence
   // -----------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_key_extremes();
      test_key_extremes();
      test_round_trip();
      test_random_traffic(300, 29, 64);
      test_random_traffic(300, 64, 29);
      test_random_traffic(300, 0, 0);
      test_backpressure(200);

      // Give any stray output block time to appear before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[xtea_block_cipher] OK");
      end else begin
         $display("[xtea_block_cipher] ERROR");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(RUN_LIMIT_NS);
      $display("[xtea_block_cipher] ERROR");
      $finish;
   end

endmodule
